// ===== rtl/core/stt_pkg.sv =====
package stt_pkg;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [1:0] KIND_WORD = 2'd0;
    localparam logic [1:0] KIND_STR  = 2'd1;
    localparam logic [1:0] KIND_BRK  = 2'd2;
    localparam logic [1:0] KIND_CMT  = 2'd3;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_END_STR = 2'd1;
    localparam logic [1:0] ERR_NL_STR  = 2'd2;
    localparam logic [1:0] ERR_BAD_ESC = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_marker;
    } t_in;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic [1:0] token_kind;
        logic       token_first;
        logic       token_last;
        logic [1:0] error_code;
        logic       run_last;
    } t_out;

    // results produced by one input word, written into the output queue
    typedef struct packed {
        logic [1:0] cnt;
        t_out       r0;
        t_out       r1;
    } t_push;

endpackage

// ===== rtl/core/stt_lexer.sv =====
module stt_lexer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  stt_pkg::t_in   i_data,
    output stt_pkg::t_push o_push
);

    typedef enum logic [2:0] {
        M_IDLE = 3'd0,
        M_WORD = 3'd1,
        M_STR  = 3'd2,
        M_ESC  = 3'd3,
        M_CMT  = 3'd4,
        M_ERR  = 3'd5
    } t_mode;

    t_mode          r_mode;
    t_mode          n_mode;
    stt_pkg::t_push push;

    function automatic stt_pkg::t_out mk(input logic [7:0] ch, input logic vld,
                                         input logic [1:0] kind, input logic first,
                                         input logic last, input logic [1:0] err);
        stt_pkg::t_out r;
        r.out_char    = ch;
        r.char_valid  = vld;
        r.token_kind  = kind;
        r.token_first = first;
        r.token_last  = last;
        r.error_code  = err;
        r.run_last    = 1'b0;
        return r;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A;
    endfunction

    function automatic logic is_brk(input logic [7:0] c);
        return c == 8'h5B || c == 8'h5D;
    endfunction

    // token start from idle: result and next mode
    function automatic stt_pkg::t_out start_res(input logic [7:0] c);
        stt_pkg::t_out r;
        if (is_brk(c)) begin
            r = mk(c, 1'b1, stt_pkg::KIND_BRK, 1'b1, 1'b1, stt_pkg::ERR_NONE);
        end else if (c == 8'h22) begin
            r = mk(c, 1'b1, stt_pkg::KIND_STR, 1'b1, 1'b0, stt_pkg::ERR_NONE);
        end else if (c == 8'h23) begin
            r = mk(c, 1'b1, stt_pkg::KIND_CMT, 1'b1, 1'b0, stt_pkg::ERR_NONE);
        end else begin
            r = mk(c, 1'b1, stt_pkg::KIND_WORD, 1'b1, 1'b0, stt_pkg::ERR_NONE);
        end
        return r;
    endfunction

    function automatic t_mode start_mode(input logic [7:0] c);
        t_mode m;
        if (is_space(c) || is_brk(c)) begin
            m = M_IDLE;
        end else if (c == 8'h22) begin
            m = M_STR;
        end else if (c == 8'h23) begin
            m = M_CMT;
        end else begin
            m = M_WORD;
        end
        return m;
    endfunction

    always_comb begin
        logic [7:0] c;
        logic [7:0] d;
        logic       esc_ok;
        c        = i_data.data_byte;
        n_mode   = r_mode;
        push.cnt = 2'd0;
        push.r0  = '0;
        push.r1  = '0;

        esc_ok = 1'b1;
        case (c)
            8'h62:   d = 8'h08;
            8'h66:   d = 8'h0C;
            8'h6E:   d = 8'h0A;
            8'h72:   d = 8'h0D;
            8'h74:   d = 8'h09;
            8'h5C:   d = 8'h5C;
            8'h27:   d = 8'h27;
            8'h22:   d = 8'h22;
            default: begin
                d      = 8'h00;
                esc_ok = 1'b0;
            end
        endcase

        if (i_data.end_marker) begin
            n_mode = M_IDLE;
            unique case (r_mode) inside
                M_WORD: begin
                    push.cnt = 2'd1;
                    push.r0  = mk(8'h00, 1'b0, stt_pkg::KIND_WORD, 1'b0, 1'b1,
                                  stt_pkg::ERR_NONE);
                end
                M_CMT: begin
                    push.cnt = 2'd1;
                    push.r0  = mk(8'h00, 1'b0, stt_pkg::KIND_CMT, 1'b0, 1'b1,
                                  stt_pkg::ERR_NONE);
                end
                M_STR, M_ESC: begin
                    push.cnt = 2'd1;
                    push.r0  = mk(8'h00, 1'b0, stt_pkg::KIND_STR, 1'b0, 1'b1,
                                  stt_pkg::ERR_END_STR);
                end
                default: ;
            endcase
        end else begin
            unique case (r_mode)
                M_WORD: begin
                    if (is_space(c) || c == 8'h22 || is_brk(c)) begin
                        // close the word, then the delimiter may open its own token
                        push.r0  = mk(8'h00, 1'b0, stt_pkg::KIND_WORD, 1'b0, 1'b1,
                                      stt_pkg::ERR_NONE);
                        push.r1  = start_res(c);
                        push.cnt = is_space(c) ? 2'd1 : 2'd2;
                        n_mode   = start_mode(c);
                    end else begin
                        push.cnt = 2'd1;
                        push.r0  = mk(c, 1'b1, stt_pkg::KIND_WORD, 1'b0, 1'b0,
                                      stt_pkg::ERR_NONE);
                    end
                end
                M_STR: begin
                    if (c == 8'h22) begin
                        push.cnt = 2'd1;
                        push.r0  = mk(c, 1'b1, stt_pkg::KIND_STR, 1'b0, 1'b1,
                                      stt_pkg::ERR_NONE);
                        n_mode   = M_IDLE;
                    end else if (c == 8'h0A) begin
                        push.cnt = 2'd1;
                        push.r0  = mk(8'h00, 1'b0, stt_pkg::KIND_STR, 1'b0, 1'b1,
                                      stt_pkg::ERR_NL_STR);
                        n_mode   = M_ERR;
                    end else if (c == 8'h5C) begin
                        n_mode = M_ESC;
                    end else begin
                        push.cnt = 2'd1;
                        push.r0  = mk(c, 1'b1, stt_pkg::KIND_STR, 1'b0, 1'b0,
                                      stt_pkg::ERR_NONE);
                    end
                end
                M_ESC: begin
                    push.cnt = 2'd1;
                    if (esc_ok) begin
                        push.r0 = mk(d, 1'b1, stt_pkg::KIND_STR, 1'b0, 1'b0,
                                     stt_pkg::ERR_NONE);
                        n_mode  = M_STR;
                    end else begin
                        push.r0 = mk(8'h00, 1'b0, stt_pkg::KIND_STR, 1'b0, 1'b1,
                                     stt_pkg::ERR_BAD_ESC);
                        n_mode  = M_ERR;
                    end
                end
                M_CMT: begin
                    push.cnt = 2'd1;
                    if (c == 8'h0A || c == 8'h0D) begin
                        push.r0 = mk(8'h00, 1'b0, stt_pkg::KIND_CMT, 1'b0, 1'b1,
                                     stt_pkg::ERR_NONE);
                        n_mode  = M_IDLE;
                    end else begin
                        push.r0 = mk(c, 1'b1, stt_pkg::KIND_CMT, 1'b0, 1'b0,
                                     stt_pkg::ERR_NONE);
                    end
                end
                M_ERR: ;
                default: begin
                    push.r0  = start_res(c);
                    push.cnt = is_space(c) ? 2'd0 : 2'd1;
                    n_mode   = start_mode(c);
                end
            endcase
        end

        if (push.cnt == 2'd1) begin
            push.r0.run_last = 1'b1;
        end else if (push.cnt == 2'd2) begin
            push.r1.run_last = 1'b1;
        end

        if (!i_fire) begin
            push.cnt = 2'd0;
            n_mode   = r_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
        end else begin
            r_mode <= n_mode;
        end
    end

    assign o_push = push;

    // a pair of results always starts with the close of a word
    a_pair_closes_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.cnt == 2'd2 |-> push.r0.token_last && push.r0.token_kind == stt_pkg::KIND_WORD)
        else $error("two results without a word close first");

    // an error result other than at end of input drops the lexer into the error mode
    a_err_to_err_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.cnt != 2'd0 && push.r0.error_code != stt_pkg::ERR_NONE
            && !i_data.end_marker |=> r_mode == M_ERR)
        else $error("error result without entering error mode");

endmodule

// ===== rtl/core/stt_out_queue.sv =====
module stt_out_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  stt_pkg::t_push i_push,
    output logic           o_room2,
    output logic           o_valid,
    input  logic           i_ready,
    output stt_pkg::t_out  o_data
);

    stt_pkg::t_out                 r_mem [stt_pkg::QDEPTH];
    logic [stt_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [stt_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [stt_pkg::QCNT_W-1:0]    r_count;
    logic [stt_pkg::QPTR_W-1:0]    wr_ptr1;
    logic                          pop;

    assign wr_ptr1 = r_wr_ptr + stt_pkg::QPTR_W'(1);
    assign pop     = o_valid && i_ready;
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    // room for a full pair, independent of the downstream ready
    assign o_room2 = r_count <= stt_pkg::QCNT_W'(stt_pkg::QDEPTH - 2);

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.r0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_ptr1] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + stt_pkg::QPTR_W'(i_push.cnt);
            r_rd_ptr <= r_rd_ptr + stt_pkg::QPTR_W'(pop);
            r_count  <= r_count + stt_pkg::QCNT_W'(i_push.cnt)
                        - stt_pkg::QCNT_W'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.cnt != 2'd0 |-> o_room2)
        else $error("push into a queue without room");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= stt_pkg::QCNT_W'(stt_pkg::QDEPTH))
        else $error("queue count beyond depth");

endmodule

// ===== rtl/core/scene_text_tokenizer.sv =====
// Byte-serial lexer for scene description text. One input word is one text
// byte or an end-of-input mark; the output is a stream of token characters
// tagged with kind, first/last and error flags. A byte is taken every clock:
// the input register feeds the lexer state machine, and its zero, one or
// two result words go into a four-word output queue. The output side moves
// one word per clock while downstream is ready, so a byte that yields two
// words (a word token closed by a quote or bracket) takes two output slots;
// the input stalls only when the queue has no room for a pair.
module scene_text_tokenizer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  stt_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output stt_pkg::t_out o_out_data
);

    logic           r_in_valid;
    stt_pkg::t_in   r_in_data;
    logic           room2;
    logic           fire;
    stt_pkg::t_push push;

    assign fire       = r_in_valid && room2;
    assign o_in_ready = !r_in_valid || room2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_data <= i_in_data;
        end
    end

    stt_lexer u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_data  (r_in_data),
        .o_push  (push)
    );

    stt_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room2 (room2),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

// ===== tb/scene_text_tokenizer_tb.sv =====
module scene_text_tokenizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASE_WORDS  = 520;
    localparam int STALL_AT     = 1250;
    localparam int STALL_CYCLES = 400;

    localparam logic [7:0] CH_BKSP   = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_LBRK   = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRK   = 8'h5D;
    localparam logic [7:0] ESC_B     = 8'h62;
    localparam logic [7:0] ESC_F     = 8'h66;
    localparam logic [7:0] ESC_N     = 8'h6E;
    localparam logic [7:0] ESC_R     = 8'h72;
    localparam logic [7:0] ESC_T     = 8'h74;

    typedef enum logic [2:0] {
        LX_IDLE = 3'd0,
        LX_WORD = 3'd1,
        LX_STR  = 3'd2,
        LX_ESC  = 3'd3,
        LX_CMT  = 3'd4,
        LX_ERR  = 3'd5
    } lex_mode_e;

    class token_scoreboard;
        lex_mode_e     mode;
        stt_pkg::t_out expected_q[$];
        stt_pkg::t_out step_q[$];
        int            mismatches;
        int            live_words;

        function new();
            mode = LX_IDLE;
            mismatches = 0;
            live_words = 0;
        endfunction

        static function bit is_blank(logic [7:0] c);
            return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
        endfunction

        function void add(logic [7:0] ch, logic valid, logic [1:0] kind, logic first,
                          logic last, logic [1:0] err);
            stt_pkg::t_out r;
            r.out_char    = ch;
            r.char_valid  = valid;
            r.token_kind  = kind;
            r.token_first = first;
            r.token_last  = last;
            r.error_code  = err;
            r.run_last    = 1'b0;
            step_q.insert(step_q.size(), r);
        endfunction

        function void open_token(logic [7:0] c);
            if (is_blank(c)) begin
                mode = LX_IDLE;
            end else if (c == CH_LBRK || c == CH_RBRK) begin
                mode = LX_IDLE;
                add(c, 1'b1, stt_pkg::KIND_BRK, 1'b1, 1'b1, stt_pkg::ERR_NONE);
            end else if (c == CH_QUOTE) begin
                mode = LX_STR;
                add(c, 1'b1, stt_pkg::KIND_STR, 1'b1, 1'b0, stt_pkg::ERR_NONE);
            end else if (c == CH_HASH) begin
                mode = LX_CMT;
                add(c, 1'b1, stt_pkg::KIND_CMT, 1'b1, 1'b0, stt_pkg::ERR_NONE);
            end else begin
                mode = LX_WORD;
                add(c, 1'b1, stt_pkg::KIND_WORD, 1'b1, 1'b0, stt_pkg::ERR_NONE);
            end
        endfunction

        // works out the token words that one accepted input word produces
        function void note_input(stt_pkg::t_in w);
            logic [7:0] c;
            logic [7:0] d;
            bit         known;
            step_q.delete();
            c = w.data_byte;
            if (mode != LX_ERR)
                live_words++;
            if (w.end_marker) begin
                case (mode) inside
                    LX_WORD: add(8'h00, 1'b0, stt_pkg::KIND_WORD, 1'b0, 1'b1,
                                 stt_pkg::ERR_NONE);
                    LX_CMT:  add(8'h00, 1'b0, stt_pkg::KIND_CMT, 1'b0, 1'b1,
                                 stt_pkg::ERR_NONE);
                    LX_STR, LX_ESC: add(8'h00, 1'b0, stt_pkg::KIND_STR, 1'b0, 1'b1,
                                        stt_pkg::ERR_END_STR);
                    default: ;
                endcase
                mode = LX_IDLE;
            end else begin
                case (mode)
                    LX_WORD: begin
                        if (is_blank(c) || c == CH_QUOTE || c == CH_LBRK || c == CH_RBRK) begin
                            add(8'h00, 1'b0, stt_pkg::KIND_WORD, 1'b0, 1'b1,
                                stt_pkg::ERR_NONE);
                            open_token(c);
                        end else begin
                            add(c, 1'b1, stt_pkg::KIND_WORD, 1'b0, 1'b0, stt_pkg::ERR_NONE);
                        end
                    end
                    LX_STR: begin
                        if (c == CH_QUOTE) begin
                            add(c, 1'b1, stt_pkg::KIND_STR, 1'b0, 1'b1, stt_pkg::ERR_NONE);
                            mode = LX_IDLE;
                        end else if (c == CH_LF) begin
                            add(8'h00, 1'b0, stt_pkg::KIND_STR, 1'b0, 1'b1,
                                stt_pkg::ERR_NL_STR);
                            mode = LX_ERR;
                        end else if (c == CH_BSLASH) begin
                            mode = LX_ESC;
                        end else begin
                            add(c, 1'b1, stt_pkg::KIND_STR, 1'b0, 1'b0, stt_pkg::ERR_NONE);
                        end
                    end
                    LX_ESC: begin
                        known = 1'b1;
                        case (c)
                            ESC_B:     d = CH_BKSP;
                            ESC_F:     d = CH_FF;
                            ESC_N:     d = CH_LF;
                            ESC_R:     d = CH_CR;
                            ESC_T:     d = CH_TAB;
                            CH_BSLASH: d = CH_BSLASH;
                            CH_APOS:   d = CH_APOS;
                            CH_QUOTE:  d = CH_QUOTE;
                            default: begin
                                d = 8'h00;
                                known = 1'b0;
                            end
                        endcase
                        if (known) begin
                            add(d, 1'b1, stt_pkg::KIND_STR, 1'b0, 1'b0, stt_pkg::ERR_NONE);
                            mode = LX_STR;
                        end else begin
                            add(8'h00, 1'b0, stt_pkg::KIND_STR, 1'b0, 1'b1,
                                stt_pkg::ERR_BAD_ESC);
                            mode = LX_ERR;
                        end
                    end
                    LX_CMT: begin
                        if (c == CH_LF || c == CH_CR) begin
                            add(8'h00, 1'b0, stt_pkg::KIND_CMT, 1'b0, 1'b1,
                                stt_pkg::ERR_NONE);
                            mode = LX_IDLE;
                        end else begin
                            add(c, 1'b1, stt_pkg::KIND_CMT, 1'b0, 1'b0, stt_pkg::ERR_NONE);
                        end
                    end
                    LX_ERR: ;
                    default: open_token(c);
                endcase
            end
            if (step_q.size() > 0)
                step_q[step_q.size() - 1].run_last = 1'b1;
            foreach (step_q[i])
                expected_q.insert(expected_q.size(), step_q[i]);
        endfunction

        function void check_result(stt_pkg::t_out got);
            stt_pkg::t_out exp_w;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected word char=%h valid=%b kind=%0d", $realtime,
                             got.out_char, got.char_valid, got.token_kind);
                return;
            end
            exp_w = expected_q.pop_front();
            if (got.out_char !== exp_w.out_char || got.char_valid !== exp_w.char_valid ||
                got.token_kind !== exp_w.token_kind || got.token_first !== exp_w.token_first ||
                got.token_last !== exp_w.token_last || got.error_code !== exp_w.error_code ||
                got.run_last !== exp_w.run_last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: mismatch char/valid/kind/first/last/err/run_last ",
                              "exp %h %b %0d %b %b %0d %b got %h %b %0d %b %b %0d %b"},
                             $realtime, exp_w.out_char, exp_w.char_valid, exp_w.token_kind,
                             exp_w.token_first, exp_w.token_last, exp_w.error_code,
                             exp_w.run_last, got.out_char, got.char_valid, got.token_kind,
                             got.token_first, got.token_last, got.error_code, got.run_last);
            end
        endfunction
    endclass

    logic          i_clk     = 1'b0;
    logic          i_rst_n   = 1'b0;
    logic          in_valid  = 1'b0;
    stt_pkg::t_in  in_data   = '0;
    logic          out_ready = 1'b0;
    logic          in_ready;
    logic          out_valid;
    stt_pkg::t_out out_data;

    token_scoreboard tokens = new();
    int send_idle_pct = 30;
    int recv_idle_pct = 71;
    int hold_left     = 0;
    bit stall_done    = 1'b0;
    int cycle_count   = 0;

    scene_text_tokenizer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("scene_text_tokenizer_tb: errors");
            $finish;
        end
    end

    // output side: check accepted words, random back-pressure, one long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready)
            tokens.check_result(out_data);
        if (!stall_done && tokens.live_words >= STALL_AT) begin
            stall_done = 1'b1;
            hold_left = STALL_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_word(stt_pkg::t_in w);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge i_clk);
        while (!in_ready)
            @(posedge i_clk);
        tokens.note_input(w);
    endtask

    task automatic send_byte(logic [7:0] b);
        send_word('{data_byte: b, end_marker: 1'b0});
    endtask

    task automatic send_end();
        send_word('{data_byte: 8'($urandom_range(255)), end_marker: 1'b1});
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    function automatic logic [7:0] word_byte(bit lead);
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(255));
        end while (token_scoreboard::is_blank(b) || b == CH_QUOTE || b == CH_LBRK ||
                   b == CH_RBRK || (lead && b == CH_HASH));
        return b;
    endfunction

    function automatic logic [7:0] blank_byte();
        case ($urandom_range(3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic logic [7:0] escape_letter();
        case ($urandom_range(7))
            0:       return ESC_B;
            1:       return ESC_F;
            2:       return ESC_N;
            3:       return ESC_R;
            4:       return ESC_T;
            5:       return CH_BSLASH;
            6:       return CH_APOS;
            default: return CH_QUOTE;
        endcase
    endfunction

    function automatic logic [7:0] bad_escape();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(255));
        end while (b == ESC_B || b == ESC_F || b == ESC_N || b == ESC_R || b == ESC_T ||
                   b == CH_BSLASH || b == CH_APOS || b == CH_QUOTE);
        return b;
    endfunction

    task automatic send_string_char();
        logic [7:0] b;
        if ($urandom_range(3) == 0) begin
            send_byte(CH_BSLASH);
            send_byte(escape_letter());
        end else begin
            do begin
                b = 8'($urandom_range(255));
            end while (b == CH_QUOTE || b == CH_LF || b == CH_BSLASH);
            send_byte(b);
        end
    endtask

    // mostly well-formed tokens, plus raw noise and broken strings
    task automatic send_random_run();
        int         pick;
        logic [7:0] b;
        pick = $urandom_range(99);
        if (pick < 70) begin
            case ($urandom_range(3))
                0: begin
                    send_byte(word_byte(1'b1));
                    repeat ($urandom_range(0, 5)) send_byte(word_byte(1'b0));
                end
                1: begin
                    send_byte(CH_QUOTE);
                    repeat ($urandom_range(0, 6)) send_string_char();
                    send_byte(CH_QUOTE);
                end
                2: begin
                    send_byte(CH_HASH);
                    repeat ($urandom_range(0, 5)) begin
                        do begin
                            b = 8'($urandom_range(255));
                        end while (b == CH_CR || b == CH_LF);
                        send_byte(b);
                    end
                    send_byte($urandom_range(1) ? CH_CR : CH_LF);
                end
                default: send_byte($urandom_range(1) ? CH_LBRK : CH_RBRK);
            endcase
            case ($urandom_range(9)) inside
                0: send_end();
                [1:6]: send_byte(blank_byte());
                default: ;
            endcase
        end else if (pick < 85) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
        end else if (pick < 95) begin
            send_byte(CH_QUOTE);
            repeat ($urandom_range(0, 3)) send_string_char();
            case ($urandom_range(2))
                0: send_byte(CH_LF);
                1: begin
                    send_byte(CH_BSLASH);
                    send_byte(bad_escape());
                end
                default: ;
            endcase
            repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(255)));
            send_end();
        end else begin
            send_end();
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: byte extremes, '#' inside a word, word closed by a bracket
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("#[");
        // escape, bad escape, dropped byte, end clears the error
        send_text("\"\\n\\q");
        send_byte(8'h78);
        send_end();
        send_end();
        // comments closed by CR, LF and end of input
        send_text("#a\015#\n#");
        send_end();
        // CR is plain inside a string, LF is an error
        send_text("\"\015\n");
        send_end();
        // end right after a backslash
        send_text("\"\\");
        send_end();
        // word closed by a quote, then end inside the string
        send_text("w\"");
        send_end();
        send_text("\"\\t\"]a");
        send_end();
        send_text("\t ");

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 30;
                    recv_idle_pct = 71;
                end
                1: begin
                    send_idle_pct = 71;
                    recv_idle_pct = 30;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            while (tokens.live_words < (phase + 1) * PHASE_WORDS)
                send_random_run();
        end
        in_valid <= 1'b0;

        while (tokens.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (tokens.mismatches == 0 && tokens.expected_q.size() == 0)
            $display("scene_text_tokenizer_tb: clean");
        else
            $display("scene_text_tokenizer_tb: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/stt_pkg.sv
rtl/core/stt_lexer.sv
rtl/core/stt_out_queue.sv
rtl/core/scene_text_tokenizer.sv
tb/scene_text_tokenizer_tb.sv
